>>> sv/ckrl_pkg.sv
// shared types and codes for the colour keyed region labeler
// request and result structs, status and mode codes, default sizes
// no dependencies
package ckrl_pkg;

  localparam int COLOUR_W            = 24;
  localparam int IDX_OUT_W           = 9;
  localparam int DEFAULT_MAX_REGIONS = 256;

  localparam logic [1:0] MODE_ADD        = 2'd0;
  localparam logic [1:0] MODE_WATER      = 2'd1;
  localparam logic [1:0] MODE_LOCK_WATER = 2'd2;
  localparam logic [1:0] MODE_PIXEL      = 2'd3;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_FULL          = 4'd1;
  localparam logic [3:0] ST_BAD_COLOUR    = 4'd2;
  localparam logic [3:0] ST_DUPLICATE     = 4'd3;
  localparam logic [3:0] ST_BAD_INDEX     = 4'd4;
  localparam logic [3:0] ST_ALREADY_WATER = 4'd5;
  localparam logic [3:0] ST_WATER_LOCKED  = 4'd6;
  localparam logic [3:0] ST_UNKNOWN       = 4'd7;
  localparam logic [3:0] ST_ADD_LOCKED    = 4'd8;

  typedef struct packed {
    logic [1:0]           mode;
    logic [COLOUR_W-1:0]  colour;
    logic [IDX_OUT_W-1:0] region_number;
    logic                 last_pixel;
  } in_req_t;

  typedef struct packed {
    logic [3:0]           status;
    logic [IDX_OUT_W-1:0] found_index;
    logic                 is_land;
    logic [IDX_OUT_W-1:0] missing_count;
  } out_res_t;

endpackage

>>> sv/colour_keyed_region_labeler.sv
// colour keyed region labeler: region colour table with water and seen flags
// one region memory, scanned entry by entry under a small sequencer
// depends on ckrl_pkg
//
// usage: a request is taken when start is high and busy is low; in_data holds
// mode, colour, region_number and last_pixel. every request gives one result
// on out_data, marked by out_valid for exactly one cycle; the receiver cannot
// stall, so results are never held back.
// work per request:
//   lock water, full table, zero colour on add: result the cycle after accept
//   mark water: rejections from idle, else after reading the entry's flag
//   add, pixel: a table scan reading one entry per cycle, up to a match
//   last pixel: a further pass to count unseen regions and clear seen flags
// busy, if raised, stays high until the result strobe; the next request may
// follow in the cycle of the strobe.
// reset: synchronous, active low. after reset a clearing pass writes every
// memory entry with busy high.
module colour_keyed_region_labeler
  import ckrl_pkg::*;
#(
  parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_valid,
  output out_res_t out_data
);

  localparam int IDX_W = (MAX_REGIONS > 2) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW    = $clog2(MAX_REGIONS + 1);
  localparam int XW    = (CW > IDX_OUT_W) ? CW : IDX_OUT_W;

  typedef struct packed {
    logic                seen;
    logic                water;
    logic [COLOUR_W-1:0] colour;
  } ent_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WCHK  = 5'b01000,
    S_SWEEP = 5'b10000
  } state_t;

  function automatic logic [IDX_OUT_W-1:0] to_out(input logic [CW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[IDX_OUT_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  in_req_t           req_r, req_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              water_lock_r, water_lock_nxt;
  logic              add_lock_r, add_lock_nxt;
  logic [CW-1:0]     missing_r, missing_nxt;
  out_res_t          pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_data_r, out_data_nxt;

  ent_t              mem [MAX_REGIONS];
  ent_t              rdata_r;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic              we;
  ent_t              wdata;

  logic [XW-1:0]     rnum_x;
  logic [XW-1:0]     rnum_m1;
  logic              hit;
  logic [CW-1:0]     hit_num;
  out_res_t          res;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rnum_x  = XW'(in_data.region_number);
  assign rnum_m1 = rnum_x - XW'(1);
  assign hit     = rd_v_r && (rdata_r.colour == req_r.colour);
  assign hit_num = CW'(cmp_idx_r) + CW'(1);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    cmp_idx_nxt    = cmp_idx_r;
    rd_v_nxt       = 1'b0;
    count_nxt      = count_r;
    water_lock_nxt = water_lock_r;
    add_lock_nxt   = add_lock_r;
    missing_nxt    = missing_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    raddr          = addr_r[IDX_W-1:0];
    waddr          = cmp_idx_r;
    we             = 1'b0;
    wdata          = rdata_r;
    res            = '0;

    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = addr_r[IDX_W-1:0];
        wdata = '0;
        if (addr_r == CW'(MAX_REGIONS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + CW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          req_nxt  = in_data;
          addr_nxt = '0;
          case (in_data.mode)
            MODE_ADD: begin
              if (count_r == CW'(MAX_REGIONS)) begin
                res.status    = ST_FULL;
                out_valid_nxt = 1'b1;
                out_data_nxt  = res;
              end else if (in_data.colour == '0) begin
                res.status    = ST_BAD_COLOUR;
                out_valid_nxt = 1'b1;
                out_data_nxt  = res;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_WATER: begin
              raddr = rnum_m1[IDX_W-1:0];
              if (water_lock_r) begin
                res.status    = ST_WATER_LOCKED;
                out_valid_nxt = 1'b1;
                out_data_nxt  = res;
              end else if (rnum_x == '0 || rnum_x > XW'(count_r)) begin
                res.status    = ST_BAD_INDEX;
                out_valid_nxt = 1'b1;
                out_data_nxt  = res;
              end else begin
                cmp_idx_nxt = rnum_m1[IDX_W-1:0];
                state_nxt   = S_WCHK;
              end
            end
            MODE_LOCK_WATER: begin
              water_lock_nxt = 1'b1;
              out_valid_nxt  = 1'b1;
              out_data_nxt   = res;
            end
            MODE_PIXEL: begin
              add_lock_nxt = 1'b1;
              missing_nxt  = '0;
              if (in_data.colour == '0) begin
                res.status = ST_UNKNOWN;
                if (in_data.last_pixel) begin
                  pend_nxt  = res;
                  state_nxt = S_SWEEP;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = res;
                end
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit || addr_r == count_r) begin
          if (req_r.mode == MODE_ADD) begin
            if (hit) begin
              res.status = ST_DUPLICATE;
            end else if (add_lock_r) begin
              res.status = ST_ADD_LOCKED;
            end else begin
              we              = 1'b1;
              waddr           = count_r[IDX_W-1:0];
              wdata           = '0;
              wdata.colour    = req_r.colour;
              count_nxt       = count_r + CW'(1);
              res.found_index = to_out(count_r + CW'(1));
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
            state_nxt     = S_IDLE;
          end else begin
            if (hit) begin
              we              = 1'b1;
              wdata.seen      = 1'b1;
              res.found_index = to_out(hit_num);
              res.is_land     = !rdata_r.water;
            end else begin
              res.status = ST_UNKNOWN;
            end
            addr_nxt = '0;
            if (req_r.last_pixel) begin
              pend_nxt  = res;
              state_nxt = S_SWEEP;
            end else begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = res;
              state_nxt     = S_IDLE;
            end
          end
        end else begin
          rd_v_nxt    = 1'b1;
          cmp_idx_nxt = addr_r[IDX_W-1:0];
          addr_nxt    = addr_r + CW'(1);
        end
      end

      S_WCHK: begin
        res = '0;
        if (rdata_r.water) begin
          res.status = ST_ALREADY_WATER;
        end else begin
          we          = 1'b1;
          wdata.water = 1'b1;
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
        state_nxt     = S_IDLE;
      end

      S_SWEEP: begin
        if (rd_v_r) begin
          we         = 1'b1;
          wdata.seen = 1'b0;
          if (!rdata_r.seen) begin
            missing_nxt = missing_r + CW'(1);
          end
        end
        if (addr_r == count_r) begin
          res               = pend_r;
          res.missing_count = to_out(missing_nxt);
          out_valid_nxt     = 1'b1;
          out_data_nxt      = res;
          state_nxt         = S_IDLE;
        end else begin
          rd_v_nxt    = 1'b1;
          cmp_idx_nxt = addr_r[IDX_W-1:0];
          addr_nxt    = addr_r + CW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      addr_r       <= '0;
      rd_v_r       <= 1'b0;
      count_r      <= '0;
      water_lock_r <= 1'b0;
      add_lock_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      rd_v_r       <= rd_v_nxt;
      count_r      <= count_nxt;
      water_lock_r <= water_lock_nxt;
      add_lock_r   <= add_lock_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    missing_r  <= missing_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REGIONS))
    else $error("region count beyond capacity");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request neither started nor answered");

  a_add_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(add_lock_r) |-> add_lock_r)
    else $error("adding lock released");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_ADD_LOCKED)
    else $error("status code out of range");

endmodule
